### design/thp_pkg.sv
package thp_pkg;

  // Stream widths: input payload is 35 bits padded to 40, result payload 131 bits padded to 136.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 136;

  localparam logic [23:0] WINDOW_LIMIT_RESET = 24'd500;

  // Result status codes.
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_FLAGS_BAD    = 3'd1;
  localparam logic [2:0] ST_OUT_OF_WIN   = 3'd2;
  localparam logic [2:0] ST_RESET        = 3'd3;
  localparam logic [2:0] ST_UNEXP_SYN    = 3'd4;

  // Result kinds.
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_OPTION = 1'b1;

  // One result as it travels from the front end through the queue to the output stage.
  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [23:0] seq_number;
    logic [23:0] ack_number;
    logic [31:0] window_size;
    logic [3:0]  flag_bits;
    logic [3:0]  version_number;
    logic [7:0]  option_count;
    logic [7:0]  option_type;
    logic [23:0] option_info;
    logic        last;
  } res_t;

endpackage

### design/thp_front.sv
module thp_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [thp_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                           in_tuser,
  input  logic                           cfg_valid,
  input  logic [23:0]                    cfg_data,
  input  logic                           q_full,
  output logic                           push,
  output thp_pkg::res_t                  push_res
);

  localparam logic [3:0] POS_ACK = 4'd3;
  localparam logic [3:0] POS_WIN = 4'd6;
  localparam logic [3:0] POS_FV  = 4'd10;
  localparam logic [3:0] POS_CNT = 4'd11;

  localparam logic [2:0] CTX_DATA        = 3'd0;
  localparam logic [2:0] CTX_SYN_SENT    = 3'd1;
  localparam logic [2:0] CTX_SYN_RECV    = 3'd2;
  localparam logic [2:0] CTX_SYNACK_SENT = 3'd3;
  localparam logic [2:0] CTX_FIN_SENT    = 3'd4;
  localparam logic [2:0] CTX_FINACK_SENT = 3'd5;
  localparam logic [2:0] CTX_SYN_EXP     = 3'd6;
  localparam logic [2:0] CTX_NONE        = 3'd7;

  localparam logic [3:0] FL_NONE   = 4'b0000;
  localparam logic [3:0] FL_ACK    = 4'b0010;
  localparam logic [3:0] FL_FIN    = 4'b0100;
  localparam logic [3:0] FL_FINACK = 4'b0110;
  localparam logic [3:0] FL_SYN    = 4'b1000;
  localparam logic [3:0] FL_SYNFIN = 4'b1100;

  localparam logic [3:0] VERSION_OPTIONS = 4'd3;

  logic [7:0]  data_b;
  logic [2:0]  ctx_in;
  logic [23:0] exp_in;
  logic        accept;

  logic [3:0]  pos_r, pos_nxt, pos_b;
  logic        done_r, done_nxt, done_b;
  logic [7:0]  optleft_r, optleft_nxt, optleft_b;
  logic [1:0]  slot_r, slot_nxt;
  logic [23:0] optacc_r, optacc_nxt;
  logic [23:0] seq_r, seq_nxt;
  logic [23:0] ack_r, ack_nxt;
  logic [31:0] win_r, win_nxt;
  logic [7:0]  fv_r, fv_nxt;
  logic [2:0]  ctx_r, ctx_nxt;
  logic [23:0] exp_r, exp_nxt;
  logic        oow_r, oow_nxt;
  logic [23:0] wlim_r, wlim_nxt;

  logic [24:0] win_end;
  logic [23:0] seq_dist;
  logic        oow_calc;
  logic        syn_ok;
  logic        flags_ok;
  logic [2:0]  st;
  logic [7:0]  optleft_dec;

  assign data_b = in_tdata[7:0];
  assign ctx_in = in_tdata[10:8];
  assign exp_in = in_tdata[34:11];

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // Window test; the upper end either fits in 24 bits or wraps modulo 2^24.
  assign win_end  = {1'b0, exp_r} + {1'b0, wlim_r};
  assign seq_dist = seq_r - exp_r;
  assign oow_calc = (seq_r != exp_r) &&
                    (win_end[24] ? (seq_dist > wlim_r) : ({1'b0, seq_r} > win_end));

  assign syn_ok = (ctx_r == CTX_SYN_SENT) || (ctx_r == CTX_SYN_EXP);

  always_comb begin
    unique case (ctx_r)
      CTX_DATA, CTX_SYN_RECV: flags_ok = (fv_r[7:4] == FL_ACK) || (fv_r[7:4] == FL_NONE);
      CTX_SYN_SENT:           flags_ok = (fv_r[7:4] == FL_SYNFIN);
      CTX_SYNACK_SENT:        flags_ok = (fv_r[7:4] == FL_FIN);
      CTX_FIN_SENT:           flags_ok = (fv_r[7:4] == FL_FINACK) || (fv_r[7:4] == FL_NONE) ||
                                         (fv_r[7:4] == FL_ACK);
      CTX_FINACK_SENT:        flags_ok = (fv_r[7:4] == FL_FINACK);
      CTX_SYN_EXP:            flags_ok = (fv_r[7:4] == FL_SYN);
      CTX_NONE:               flags_ok = 1'b1;
      default:                flags_ok = 1'b1;
    endcase
  end

  always_comb begin
    if (!syn_ok && oow_r) begin
      st = thp_pkg::ST_OUT_OF_WIN;
    end else if (fv_r[4]) begin
      st = thp_pkg::ST_RESET;
    end else if (fv_r[7] && !syn_ok) begin
      st = thp_pkg::ST_UNEXP_SYN;
    end else if (!flags_ok) begin
      st = thp_pkg::ST_FLAGS_BAD;
    end else begin
      st = thp_pkg::ST_OK;
    end
  end

  assign optleft_dec = optleft_r - 8'd1;

  always_comb begin
    pos_nxt     = pos_r;
    done_nxt    = done_r;
    optleft_nxt = optleft_r;
    slot_nxt    = slot_r;
    optacc_nxt  = optacc_r;
    seq_nxt     = seq_r;
    ack_nxt     = ack_r;
    win_nxt     = win_r;
    fv_nxt      = fv_r;
    ctx_nxt     = ctx_r;
    exp_nxt     = exp_r;
    oow_nxt     = oow_r;
    wlim_nxt    = cfg_valid ? cfg_data : wlim_r;
    push        = 1'b0;
    push_res    = '0;

    pos_b     = in_tuser ? 4'd0 : pos_r;
    done_b    = in_tuser ? 1'b0 : done_r;
    optleft_b = in_tuser ? 8'd0 : optleft_r;

    if (accept) begin
      if (in_tuser) begin
        pos_nxt     = 4'd0;
        done_nxt    = 1'b0;
        optleft_nxt = 8'd0;
        ctx_nxt     = ctx_in;
        exp_nxt     = exp_in;
      end
      if (!done_b) begin
        pos_nxt = pos_b + 4'd1;
        unique case (pos_b) inside
          [4'd0:POS_ACK-4'd1]: seq_nxt = {seq_r[15:0], data_b};
          [POS_ACK:POS_WIN-4'd1]: ack_nxt = {ack_r[15:0], data_b};
          [POS_WIN:POS_FV-4'd1]: win_nxt = {win_r[23:0], data_b};
          POS_FV: begin
            fv_nxt  = data_b;
            oow_nxt = oow_calc;
          end
          default: begin
            // Option count byte: the header result goes out now.
            pos_nxt     = POS_CNT;
            optleft_nxt = ((st == thp_pkg::ST_OK) && (fv_r[3:0] == VERSION_OPTIONS)) ?
                          data_b : 8'd0;
            done_nxt    = 1'b1;
            slot_nxt    = 2'd0;
            push        = 1'b1;
            push_res.kind           = thp_pkg::KIND_HEADER;
            push_res.status         = st;
            push_res.seq_number     = seq_r;
            push_res.ack_number     = ack_r;
            push_res.window_size    = win_r;
            push_res.flag_bits      = fv_r[7:4];
            push_res.version_number = fv_r[3:0];
            push_res.option_count   = optleft_nxt;
            push_res.last           = (optleft_nxt == 8'd0);
          end
        endcase
      end else if (optleft_b != 8'd0) begin
        optacc_nxt = {optacc_r[15:0], data_b};
        slot_nxt   = slot_r + 2'd1;
        if (slot_r == 2'd3) begin
          optleft_nxt = optleft_dec;
          push        = 1'b1;
          push_res.kind           = thp_pkg::KIND_OPTION;
          push_res.status         = thp_pkg::ST_OK;
          push_res.seq_number     = seq_r;
          push_res.ack_number     = ack_r;
          push_res.window_size    = win_r;
          push_res.flag_bits      = fv_r[7:4];
          push_res.version_number = fv_r[3:0];
          push_res.option_count   = 8'd0;
          push_res.option_type    = optacc_r[23:16];
          push_res.option_info    = {optacc_r[15:0], data_b};
          push_res.last           = (optleft_dec == 8'd0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 4'd0;
      done_r    <= 1'b0;
      optleft_r <= 8'd0;
      slot_r    <= 2'd0;
      ctx_r     <= CTX_NONE;
      exp_r     <= 24'd0;
      wlim_r    <= thp_pkg::WINDOW_LIMIT_RESET;
    end else begin
      pos_r     <= pos_nxt;
      done_r    <= done_nxt;
      optleft_r <= optleft_nxt;
      slot_r    <= slot_nxt;
      ctx_r     <= ctx_nxt;
      exp_r     <= exp_nxt;
      wlim_r    <= wlim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    optacc_r <= optacc_nxt;
    seq_r    <= seq_nxt;
    ack_r    <= ack_nxt;
    win_r    <= win_nxt;
    fv_r     <= fv_nxt;
    oow_r    <= oow_nxt;
  end

endmodule

### design/thp_queue.sv
module thp_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  thp_pkg::res_t push_res,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output thp_pkg::res_t q_res
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  thp_pkg::res_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_res   = entry_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_res;
    end
  end

endmodule

### design/thp_back.sv
module thp_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  thp_pkg::res_t                   q_res,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [thp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser,
  output logic                            out_tlast
);

  logic                            valid_r, valid_nxt;
  logic [thp_pkg::OUT_TDATA_W-1:0] data_r, data_nxt;
  logic                            kind_r, kind_nxt;
  logic                            last_r, last_nxt;

  assign pop = q_valid && (!valid_r || out_tready);

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    kind_nxt  = kind_r;
    last_nxt  = last_r;
    if (pop) begin
      valid_nxt = 1'b1;
      data_nxt  = {5'd0, q_res.option_info, q_res.option_type, q_res.option_count,
                   q_res.version_number, q_res.flag_bits, q_res.window_size,
                   q_res.ack_number, q_res.seq_number, q_res.status};
      kind_nxt  = q_res.kind;
      last_nxt  = q_res.last;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    kind_r <= kind_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

### design/transport_header_parser_unit.sv
// Transport header parser.
// The input stream carries one header byte per request. in_tuser marks the first byte of a
// header; with that byte the block also samples the connection phase and the expected
// sequence number from in_tdata. Bytes 0-2 are the sequence number, 3-5 the acknowledgement,
// 6-9 the window, byte 10 flags and version, byte 11 the option count. On byte 11 one header
// result leaves on the output stream; with ok status and version 3 one option result follows
// for every further group of four bytes, up to the option count. out_tuser tells header (0)
// from option (1) results and out_tlast marks the final result of a header.
// The configuration channel writes the 24-bit window limit; it is always ready. The user must
// write it only while no header is in flight; the block itself does not enforce this.
// Throughput: one byte per cycle while the queue is not full. The front end parses a byte in
// the cycle it is accepted and writes any result into a small queue; the output stage moves
// it into the register that drives out_tvalid once that register is empty or being read.
// When the receiver stalls, results collect in the queue and in_tready falls only once the
// queue is full; bytes that produce no result are then held off too.
// Reset clears the parser to the start of a header with phase "none", expected sequence 0 and
// window limit 500, and empties the queue and the output stage.
module transport_header_parser_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata from bit 0: data_byte[7:0], context_req[10:8], expected_seq[34:11], zero pad
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [thp_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: start_of_packet
  input  logic                            in_tuser,
  // out_tdata from bit 0: status[2:0], seq_number[26:3], ack_number[50:27],
  // window_size[82:51], flag_bits[86:83], version_number[90:87], option_count[98:91],
  // option_type[106:99], option_info[130:107], zero pad
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [thp_pkg::OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: kind
  output logic                            out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [23:0]                     cfg_data
);

  logic          q_full;
  logic          push;
  thp_pkg::res_t push_res;
  logic          pop;
  logic          q_valid;
  thp_pkg::res_t q_res;

  // The window limit register accepts a write in any cycle.
  assign cfg_ready = 1'b1;

  thp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_res  (push_res)
  );

  // Results waiting for the output stage; lets parsing continue while the receiver stalls.
  thp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_res (push_res),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_res    (q_res)
  );

  thp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_res      (q_res),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### design/thp_checker.sv
module thp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [thp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            out_tlast
);

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) &&
    $stable(out_tlast))
    else $error("result changed while stalled");

  // Nothing is offered in the cycle after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // Option results carry ok status and no option count.
  a_option: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == thp_pkg::KIND_OPTION) |->
    (out_tdata[2:0] == thp_pkg::ST_OK) && (out_tdata[98:91] == 8'd0))
    else $error("option result with status or count");

  // A header result is last exactly when no options follow.
  a_hdr_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == thp_pkg::KIND_HEADER) |->
    (out_tlast == (out_tdata[98:91] == 8'd0)))
    else $error("header last does not match option count");

  // A failed header announces no options.
  a_hdr_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == thp_pkg::KIND_HEADER) &&
    (out_tdata[2:0] != thp_pkg::ST_OK) |-> (out_tdata[98:91] == 8'd0))
    else $error("options announced on a failed header");

endmodule

bind transport_header_parser_unit thp_checker u_thp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
